// ===== rtl/obbc_pkg.sv =====
// Shared widths, constants and register indexes for the opaque bounding-box crop block.
`timescale 1ns / 1ps

package obbc_pkg;

	localparam int COORD_W  = 12;   // pixel column / row
	localparam int DIM_W    = 13;   // sizes and signed crop origin
	localparam int PIXEL_W  = 32;
	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 13;

	localparam int MAX_DIM  = 4096;
	localparam int MIN_SIZE = 8;

	// min trackers start at the top of the coordinate range
	localparam logic [COORD_W-1:0] TRACK_MIN_RESET = COORD_W'(MAX_DIM - 1);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WINDOW_X       = 3'd0,
		REG_WINDOW_Y       = 3'd1,
		REG_WINDOW_WIDTH   = 3'd2,
		REG_WINDOW_HEIGHT  = 3'd3,
		REG_PICTURE_WIDTH  = 3'd4,
		REG_PICTURE_HEIGHT = 3'd5
	} reg_idx_t;

endpackage

// ===== rtl/obbc_if.sv =====
// Channel interfaces: configuration writes, pixel requests and crop results.
`timescale 1ns / 1ps

interface obbc_cfg_if import obbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [REG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface obbc_pixel_if import obbc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_col;
	logic [COORD_W-1:0] pixel_row;
	logic [PIXEL_W-1:0] pixel_value;
	logic               frame_end;

	modport source (output valid, output pixel_col, output pixel_row, output pixel_value,
		output frame_end, input ready);
	modport sink   (input valid, input pixel_col, input pixel_row, input pixel_value,
		input frame_end, output ready);
endinterface

interface obbc_crop_if import obbc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DIM_W-1:0] crop_x;
	logic signed [DIM_W-1:0] crop_y;
	logic [DIM_W-1:0]        crop_width;
	logic [DIM_W-1:0]        crop_height;
	logic                    any_opaque;

	modport source (output valid, output crop_x, output crop_y, output crop_width,
		output crop_height, output any_opaque, input ready);
	modport sink   (input valid, input crop_x, input crop_y, input crop_width,
		input crop_height, input any_opaque, output ready);
endinterface

// ===== rtl/opaque_bounding_box_crop_top.sv =====
// Top level of the opaque bounding-box crop block.
`timescale 1ns / 1ps
//
// Usage:
//  - cfg:   register writes (index 0..5: window x/y/width/height, picture
//           width/height). Always ready; unknown indexes are dropped.
//           Write only while the block is idle.
//  - pixel: one pixel request per cycle while pixel.ready is high (col,
//           row, RGBA value, frame_end). Nonzero pixels inside the window
//           and the picture update four min/max trackers.
//  - crop:  one result per frame-end request: tight box of opaque pixels (else
//           window origin), widened to at least 8, pulled back inside the picture.
// Path: the frame-end request passes input stage s1, snapshot stage s2 and
//  the output register, which drives crop.valid.
// Throughput: one pixel per cycle while not stalled (see Stall); the tracker
//  update is a single compare and select per tracker in s1.
// Stall: while a result waits on crop, non-final pixels keep flowing; s2
//  holds a second frame snapshot, and only a further frame end then backs up
//  to pixel.ready.
// Reset: registers take their defaults, trackers clear, no result pending.

module opaque_bounding_box_crop_top
	import obbc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	obbc_cfg_if.sink        cfg,
	obbc_pixel_if.sink      pixel,
	obbc_crop_if.source     crop
);

	localparam logic [DIM_W-1:0] MIN_SIZE_D = DIM_W'(MIN_SIZE);

	// configuration registers
	logic [COORD_W-1:0] window_x_q, window_y_q;
	logic [DIM_W-1:0]   window_width_q, window_height_q;
	logic [DIM_W-1:0]   picture_width_q, picture_height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_x_q       <= '0;
			window_y_q       <= '0;
			window_width_q   <= DIM_W'(4096);
			window_height_q  <= DIM_W'(4096);
			picture_width_q  <= DIM_W'(1920);
			picture_height_q <= DIM_W'(1080);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WINDOW_X:       window_x_q       <= cfg.data[COORD_W-1:0];
				REG_WINDOW_Y:       window_y_q       <= cfg.data[COORD_W-1:0];
				REG_WINDOW_WIDTH:   window_width_q   <= cfg.data;
				REG_WINDOW_HEIGHT:  window_height_q  <= cfg.data;
				REG_PICTURE_WIDTH:  picture_width_q  <= cfg.data;
				REG_PICTURE_HEIGHT: picture_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake chain
	logic v_s1, last_s1, v_s2, out_v_q;
	logic out_free, s2_ready, s1_go, s1_ready, s1_retire;

	assign out_free  = !out_v_q || crop.ready;
	assign s2_ready  = !v_s2 || out_free;
	assign s1_go     = !last_s1 || s2_ready;
	assign s1_ready  = !v_s1 || s1_go;
	assign s1_retire = v_s1 && s1_go;
	assign pixel.ready = s1_ready;

	// window / picture test on the incoming pixel, sums kept one bit wider
	logic in_hit;
	always_comb begin
		logic [DIM_W:0] col_end, row_end;
		col_end = {1'b0, DIM_W'(window_x_q)} + {1'b0, window_width_q};
		row_end = {1'b0, DIM_W'(window_y_q)} + {1'b0, window_height_q};
		in_hit = (pixel.pixel_value != '0)
			&& (pixel.pixel_col >= window_x_q)
			&& ((DIM_W+1)'(pixel.pixel_col) < col_end)
			&& (DIM_W'(pixel.pixel_col) < picture_width_q)
			&& (pixel.pixel_row >= window_y_q)
			&& ((DIM_W+1)'(pixel.pixel_row) < row_end)
			&& (DIM_W'(pixel.pixel_row) < picture_height_q);
	end

	// stage 1: registered pixel
	logic [COORD_W-1:0] col_s1, row_s1;
	logic               hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			col_s1  <= pixel.pixel_col;
			row_s1  <= pixel.pixel_row;
			hit_s1  <= in_hit;
			last_s1 <= pixel.frame_end;
		end
	end

	// trackers
	logic [COORD_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic               seen_q;
	logic [COORD_W-1:0] min_col_n, max_col_n, min_row_n, max_row_n;
	logic               seen_n;

	always_comb begin
		min_col_n = (hit_s1 && col_s1 < min_col_q) ? col_s1 : min_col_q;
		max_col_n = (hit_s1 && col_s1 > max_col_q) ? col_s1 : max_col_q;
		min_row_n = (hit_s1 && row_s1 < min_row_q) ? row_s1 : min_row_q;
		max_row_n = (hit_s1 && row_s1 > max_row_q) ? row_s1 : max_row_q;
		seen_n    = seen_q || hit_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_col_q <= TRACK_MIN_RESET;
			max_col_q <= '0;
			min_row_q <= TRACK_MIN_RESET;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (s1_retire) begin
			if (last_s1) begin
				min_col_q <= TRACK_MIN_RESET;
				max_col_q <= '0;
				min_row_q <= TRACK_MIN_RESET;
				max_row_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				seen_q    <= seen_n;
			end
		end
	end

	// stage 2: frame snapshot
	logic [COORD_W-1:0] min_col_s2, max_col_s2, min_row_s2, max_row_s2;
	logic               seen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= s1_retire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			min_col_s2 <= min_col_n;
			max_col_s2 <= max_col_n;
			min_row_s2 <= min_row_n;
			max_row_s2 <= max_row_n;
			seen_s2    <= seen_n;
		end
	end

	// crop: tight box or window origin, then widen small sides
	logic [DIM_W-1:0] x_c, y_c, w_c, h_c;

	always_comb begin
		logic [DIM_W-1:0] x_raw, y_raw, w_raw, h_raw;
		logic             x_over, y_over;
		if (seen_s2) begin
			x_raw = DIM_W'(min_col_s2);
			y_raw = DIM_W'(min_row_s2);
			w_raw = DIM_W'(max_col_s2) - DIM_W'(min_col_s2) + DIM_W'(1);
			h_raw = DIM_W'(max_row_s2) - DIM_W'(min_row_s2) + DIM_W'(1);
		end else begin
			x_raw = DIM_W'(window_x_q);
			y_raw = DIM_W'(window_y_q);
			w_raw = '0;
			h_raw = '0;
		end
		x_over = ({1'b0, x_raw} + {1'b0, MIN_SIZE_D}) > {1'b0, picture_width_q};
		y_over = ({1'b0, y_raw} + {1'b0, MIN_SIZE_D}) > {1'b0, picture_height_q};
		x_c = x_raw;
		w_c = w_raw;
		if (w_raw < MIN_SIZE_D) begin
			w_c = MIN_SIZE_D;
			if (x_over) x_c = picture_width_q - MIN_SIZE_D;   // may go negative
		end
		y_c = y_raw;
		h_c = h_raw;
		if (h_raw < MIN_SIZE_D) begin
			h_c = MIN_SIZE_D;
			if (y_over) y_c = picture_height_q - MIN_SIZE_D;
		end
	end

	// output register
	logic [DIM_W-1:0] crop_x_q, crop_y_q, crop_w_q, crop_h_q;
	logic             any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			crop_x_q <= x_c;
			crop_y_q <= y_c;
			crop_w_q <= w_c;
			crop_h_q <= h_c;
			any_q    <= seen_s2;
		end
	end

	assign crop.valid       = out_v_q;
	assign crop.crop_x      = $signed(crop_x_q);
	assign crop.crop_y      = $signed(crop_y_q);
	assign crop.crop_width  = crop_w_q;
	assign crop.crop_height = crop_h_q;
	assign crop.any_opaque  = any_q;

endmodule
